/* rtl/core/slfe_pkg.sv */
// Shared constants and the result record of the sync/length deframer.
package slfe_pkg;

  localparam int FRAME_BYTES  = 1024;
  localparam int HEADER_BYTES = 6;

  localparam logic [7:0] SYNC_0 = 8'h84;
  localparam logic [7:0] SYNC_1 = 8'hA9;
  localparam logic [7:0] SYNC_2 = 8'h61;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 10;
  localparam int LEN_W  = 11;
  // Payload count: a payload that fits in a frame fits in these bits.
  localparam int REM_W  = $clog2(FRAME_BYTES);
  // Rounded length before the range check: 16 bits plus the round-up carry.
  localparam int RAW_W  = 17;
  localparam logic [RAW_W-1:0] MAX_PAYLOAD = RAW_W'(FRAME_BYTES - HEADER_BYTES);

  typedef struct packed {
    logic [BYTE_W-1:0] byte_value;
    logic              kept;
    logic [POS_W-1:0]  byte_position;
    logic              candidate_dropped;
    logic              frame_done;
    logic [LEN_W-1:0]  frame_length;
  } slfe_result_t;

endpackage

/* rtl/core/sync_length_frame_extractor.sv */
// Top level of the sync-word, length-prefixed frame extractor.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------------
//   rx      | rx_valid / rx_ready  | rx_byte
//   res     | res_valid / res_ready| byte_value, kept, byte_position,
//           |                      | candidate_dropped, frame_done, frame_length
//
// One byte per cycle sustained while res_ready stays high; each byte yields exactly
// one result, loaded into the result register when its byte leaves the input
// register, which waits while the result register is still full.
// The parser state (phase, fill position, payload count) sits between the two
// registers and advances once per byte.
// Reset: synchronous, active high; clears both stage valids and the parser
// state, so the hunt starts at the first sync byte. No clearing pass.
// Stalls: a held result blocks the parser only while res_ready is low; the
// input register still takes one byte, then rx_ready drops.
module sync_length_frame_extractor (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rx_valid,
  output logic                         rx_ready,
  input  logic [slfe_pkg::BYTE_W-1:0]  rx_byte,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic [slfe_pkg::BYTE_W-1:0]  byte_value,
  output logic                         kept,
  output logic [slfe_pkg::POS_W-1:0]   byte_position,
  output logic                         candidate_dropped,
  output logic                         frame_done,
  output logic [slfe_pkg::LEN_W-1:0]   frame_length
);
  import slfe_pkg::*;

  logic              held_valid;
  logic [BYTE_W-1:0] held_byte;
  logic              out_free;
  logic              advance;
  slfe_result_t      parse_result;
  slfe_result_t      res_q;

  // Move the held byte on whenever the result register can take its result.
  assign advance = held_valid && out_free;

  slfe_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_ready   (rx_ready),
    .rx_byte    (rx_byte),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  slfe_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .byte_in (held_byte),
    .result  (parse_result)
  );

  slfe_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .result_in  (parse_result),
    .free       (out_free),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .result_out (res_q)
  );

  assign byte_value        = res_q.byte_value;
  assign kept              = res_q.kept;
  assign byte_position     = res_q.byte_position;
  assign candidate_dropped = res_q.candidate_dropped;
  assign frame_done        = res_q.frame_done;
  assign frame_length      = res_q.frame_length;

  // A completing byte is always stored and is the last byte of its frame.
  a_done_is_last_kept: assert property (@(posedge clk) disable iff (rst)
    res_valid && frame_done |->
      kept && (frame_length == {1'b0, byte_position} + LEN_W'(1)))
    else $error("frame_done without matching kept position");

  // A drop and a completion never fall on the same byte.
  a_drop_not_done: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(candidate_dropped && frame_done))
    else $error("candidate dropped on a completing byte");

  // Length and position are zero when they carry no meaning.
  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (frame_done || frame_length == '0) &&
                  (kept || byte_position == '0))
    else $error("length or position set without its flag");

  // A byte that moves on lands in the result register next cycle.
  a_advance_lands: assert property (@(posedge clk) disable iff (rst)
    held_valid && out_free |=> res_valid)
    else $error("advanced byte produced no result");

endmodule

/* rtl/core/slfe_in_stage.sv */
// Input register: holds one received byte until the parser takes it.
module slfe_in_stage (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rx_valid,
  output logic                       rx_ready,
  input  logic [slfe_pkg::BYTE_W-1:0] rx_byte,
  input  logic                       advance,
  output logic                       held_valid,
  output logic [slfe_pkg::BYTE_W-1:0] held_byte
);
  import slfe_pkg::*;

  // Free when empty or when the held byte moves on this cycle.
  assign rx_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (rx_ready) begin
      held_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) begin
      held_byte <= rx_byte;
    end
  end

endmodule

/* rtl/core/slfe_parse.sv */
// Deframer state and the per-byte decision logic.
module slfe_parse (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic [slfe_pkg::BYTE_W-1:0] byte_in,
  output slfe_pkg::slfe_result_t      result
);
  import slfe_pkg::*;

  localparam logic [2:0] PH_SYNC0       = 3'd0;
  localparam logic [2:0] PH_SYNC1       = 3'd1;
  localparam logic [2:0] PH_SYNC2       = 3'd2;
  localparam logic [2:0] PH_LEN_HI      = 3'd3;
  localparam logic [2:0] PH_LEN_LO      = 3'd4;
  localparam logic [2:0] PH_TYPE        = 3'd5;
  localparam logic [2:0] PH_PAYLOAD     = 3'd6;
  localparam logic [2:0] PH_PAYLOAD_ALT = 3'd7;

  logic [2:0]        phase, phase_next;
  logic [LEN_W-1:0]  fill, fill_next, fill_inc;
  logic [REM_W-1:0]  remaining, remaining_next;
  logic [BYTE_W-1:0] len_hi, len_hi_next;
  logic [RAW_W-1:0]  len_round;
  logic              len_bad;
  logic [BYTE_W-1:0] sync_expect;

  always_comb begin
    unique case (phase)
      PH_SYNC0: sync_expect = SYNC_0;
      PH_SYNC1: sync_expect = SYNC_1;
      default:  sync_expect = SYNC_2;
    endcase
  end

  assign fill_inc  = fill + LEN_W'(1);
  // Round an odd length up to even, carrying into the seventeenth bit.
  assign len_round = {1'b0, len_hi, byte_in} + RAW_W'(byte_in[0]);
  assign len_bad   = (len_round == '0) || (len_round > MAX_PAYLOAD);

  always_comb begin
    phase_next     = phase;
    fill_next      = fill;
    remaining_next = remaining;
    len_hi_next    = len_hi;

    result                   = '0;
    result.byte_value        = byte_in;

    unique case (phase) inside
      PH_SYNC0, PH_SYNC1, PH_SYNC2: begin
        if (byte_in == sync_expect) begin
          result.kept          = 1'b1;
          result.byte_position = fill[POS_W-1:0];
          fill_next            = fill_inc;
          phase_next           = phase + 3'd1;
        end else begin
          // Restart the hunt and retry this byte as a first sync byte.
          result.candidate_dropped = (phase != PH_SYNC0);
          fill_next                = '0;
          phase_next               = PH_SYNC0;
          if (byte_in == SYNC_0) begin
            result.kept = 1'b1;
            fill_next   = LEN_W'(1);
            phase_next  = PH_SYNC1;
          end
        end
      end
      PH_LEN_HI: begin
        result.kept          = 1'b1;
        result.byte_position = fill[POS_W-1:0];
        fill_next            = fill_inc;
        len_hi_next          = byte_in;
        phase_next           = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        result.kept          = 1'b1;
        result.byte_position = fill[POS_W-1:0];
        if (len_bad) begin
          result.candidate_dropped = 1'b1;
          fill_next                = '0;
          phase_next               = PH_SYNC0;
        end else begin
          fill_next      = fill_inc;
          remaining_next = len_round[REM_W-1:0];
          phase_next     = PH_TYPE;
        end
      end
      PH_TYPE: begin
        result.kept          = 1'b1;
        result.byte_position = fill[POS_W-1:0];
        fill_next            = fill_inc;
        phase_next           = PH_PAYLOAD;
      end
      PH_PAYLOAD, PH_PAYLOAD_ALT: begin
        result.kept          = 1'b1;
        result.byte_position = fill[POS_W-1:0];
        fill_next            = fill_inc;
        remaining_next       = remaining - REM_W'(1);
        if (remaining == REM_W'(1)) begin
          result.frame_done   = 1'b1;
          result.frame_length = fill_inc;
          fill_next           = '0;
          phase_next          = PH_SYNC0;
        end
      end
      default: begin
        phase_next = PH_SYNC0;
      end
    endcase

    // Wrap a full buffer back to the start.
    if (!result.frame_done && fill_next == LEN_W'(FRAME_BYTES)) begin
      fill_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SYNC0;
      fill      <= '0;
      remaining <= '0;
    end else if (advance) begin
      phase     <= phase_next;
      fill      <= fill_next;
      remaining <= remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      len_hi <= len_hi_next;
    end
  end

endmodule

/* rtl/core/slfe_out_stage.sv */
// Result register: holds one result until the consumer takes it.
module slfe_out_stage (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  slfe_pkg::slfe_result_t result_in,
  output logic                   free,
  output logic                   res_valid,
  input  logic                   res_ready,
  output slfe_pkg::slfe_result_t result_out
);
  import slfe_pkg::*;

  // Free when empty or when the held result is taken this cycle.
  assign free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (free) begin
      res_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

/* test/testbench.sv */
// Self-checking bench for the sync-word, length-prefixed frame extractor.
`timescale 1ns / 100ps

module testbench;
  import slfe_pkg::*;

  localparam int RANDOM_ITEMS = 650;   // stop generating once this many random bytes are queued
  localparam int TAIL_ITEMS   = 80;    // final stretch with no idling on either side
  localparam int HOLD_OFF     = 64;    // long receiver stall, in cycles
  localparam int MAX_REPORTS  = 10;
  localparam int CYCLE_LIMIT  = 200000;

  // Parser phases: hunting the three sync bytes, then the header, then payload.
  typedef enum logic [2:0] {
    HUNT_SYNC0, HUNT_SYNC1, HUNT_SYNC2, LEN_HIGH, LEN_LOW, TYPE_BYTE, PAYLOAD, PAYLOAD_ALT
  } parse_phase_t;

  // One row of the directed table; 'typed' marks a result written out by hand.
  typedef struct {
    logic [BYTE_W-1:0] rx;
    bit                typed;
    slfe_result_t      want;
  } stim_row_t;

  logic               clk;
  logic               rst;
  logic               rx_valid;
  logic               rx_ready;
  logic [BYTE_W-1:0]  rx_byte;
  logic               res_valid;
  logic               res_ready;
  logic [BYTE_W-1:0]  byte_value;
  logic               kept;
  logic [POS_W-1:0]   byte_position;
  logic               candidate_dropped;
  logic               frame_done;
  logic [LEN_W-1:0]   frame_length;

  sync_length_frame_extractor dut (
    .clk               (clk),
    .rst               (rst),
    .rx_valid          (rx_valid),
    .rx_ready          (rx_ready),
    .rx_byte           (rx_byte),
    .res_valid         (res_valid),
    .res_ready         (res_ready),
    .byte_value        (byte_value),
    .kept              (kept),
    .byte_position     (byte_position),
    .candidate_dropped (candidate_dropped),
    .frame_done        (frame_done),
    .frame_length      (frame_length)
  );

  // Parser state mirrored by the bench.
  parse_phase_t     parse_phase;
  logic [10:0]      fill_pos;
  logic [RAW_W-1:0] payload_left;

  logic [BYTE_W-1:0] tx_bytes[$];         // every byte to be offered, in order
  stim_row_t         directed_rows[$];
  slfe_result_t      pending_results[$];  // predicted results awaiting their transfer

  int  n_accepted  = 0;
  int  n_results   = 0;
  int  fail_count  = 0;
  int  cycle_count = 0;
  bit  quiet_tail  = 1'b0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic stim_row_t stim_row(input logic [7:0] rx, input bit typed, input bit k,
                                         input int pos, input bit drop, input bit done,
                                         input int len);
    stim_row_t r;
    r.rx                     = rx;
    r.typed                  = typed;
    r.want.byte_value        = rx;
    r.want.kept              = k;
    r.want.byte_position     = POS_W'(pos);
    r.want.candidate_dropped = drop;
    r.want.frame_done        = done;
    r.want.frame_length      = LEN_W'(len);
    return r;
  endfunction

  // Advance the mirrored parser by one byte and return the result it yields.
  function automatic slfe_result_t parse_byte(input logic [BYTE_W-1:0] b);
    slfe_result_t r;
    logic [7:0]   sync_want;
    r            = '0;
    r.byte_value = b;
    case (parse_phase)
      HUNT_SYNC0, HUNT_SYNC1, HUNT_SYNC2: begin
        sync_want = (parse_phase == HUNT_SYNC0) ? SYNC_0 :
                    (parse_phase == HUNT_SYNC1) ? SYNC_1 : SYNC_2;
        if (b == sync_want) begin
          r.kept          = 1'b1;
          r.byte_position = fill_pos[POS_W-1:0];
          fill_pos        = fill_pos + 1'b1;
          parse_phase     = (parse_phase == HUNT_SYNC0) ? HUNT_SYNC1 :
                            (parse_phase == HUNT_SYNC1) ? HUNT_SYNC2 : LEN_HIGH;
        end else begin
          // Drop a partial sync word, then retry this byte as a first sync byte.
          r.candidate_dropped = (parse_phase != HUNT_SYNC0);
          fill_pos            = '0;
          parse_phase         = HUNT_SYNC0;
          if (b == SYNC_0) begin
            r.kept      = 1'b1;
            fill_pos    = 11'd1;
            parse_phase = HUNT_SYNC1;
          end
        end
      end
      LEN_HIGH: begin
        payload_left    = {1'b0, b, 8'h00};
        r.kept          = 1'b1;
        r.byte_position = fill_pos[POS_W-1:0];
        fill_pos        = fill_pos + 1'b1;
        parse_phase     = LEN_LOW;
      end
      LEN_LOW: begin
        payload_left    = {1'b0, payload_left[15:8], b};
        r.kept          = 1'b1;
        r.byte_position = fill_pos[POS_W-1:0];
        fill_pos        = fill_pos + 1'b1;
        // Round odd lengths up; 0xFFFF carries into bit 16.
        if (payload_left[0]) payload_left = payload_left + 1'b1;
        if (payload_left == '0 || int'(payload_left) + HEADER_BYTES > FRAME_BYTES) begin
          r.candidate_dropped = 1'b1;
          parse_phase         = HUNT_SYNC0;
          fill_pos            = '0;
        end else begin
          parse_phase = TYPE_BYTE;
        end
      end
      TYPE_BYTE: begin
        r.kept          = 1'b1;
        r.byte_position = fill_pos[POS_W-1:0];
        fill_pos        = fill_pos + 1'b1;
        parse_phase     = PAYLOAD;
      end
      default: begin
        r.kept          = 1'b1;
        r.byte_position = fill_pos[POS_W-1:0];
        fill_pos        = fill_pos + 1'b1;
        payload_left    = payload_left - 1'b1;
      end
    endcase
    if ((parse_phase == PAYLOAD || parse_phase == PAYLOAD_ALT) && payload_left == '0) begin
      r.frame_done   = 1'b1;
      r.frame_length = fill_pos;
      parse_phase    = HUNT_SYNC0;
      fill_pos       = '0;
    end else if (int'(fill_pos) >= FRAME_BYTES) begin
      fill_pos = '0;
    end
    return r;
  endfunction

  function automatic void check_result(input slfe_result_t want, input slfe_result_t got);
    if (want.byte_value != got.byte_value || want.kept != got.kept ||
        want.byte_position != got.byte_position ||
        want.candidate_dropped != got.candidate_dropped ||
        want.frame_done != got.frame_done || want.frame_length != got.frame_length) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("result %0d mismatch: expected byte %02h kept %0b pos %0d drop %0b",
                 n_results, want.byte_value, want.kept, want.byte_position,
                 want.candidate_dropped);
        $display("  expected done %0b len %0d, got byte %02h kept %0b pos %0d",
                 want.frame_done, want.frame_length,
                 got.byte_value, got.kept, got.byte_position);
        $display("  got drop %0b done %0b len %0d",
                 got.candidate_dropped, got.frame_done, got.frame_length);
      end
    end
  endfunction

  // Queue one frame header with the given raw length; add the body only if it is legal.
  task automatic push_frame(input int len);
    int rounded;
    rounded = len + (len & 1);
    tx_bytes.push_back(SYNC_0);
    tx_bytes.push_back(SYNC_1);
    tx_bytes.push_back(SYNC_2);
    tx_bytes.push_back(8'(len >> 8));
    tx_bytes.push_back(8'(len));
    if (rounded != 0 && rounded + HEADER_BYTES <= FRAME_BYTES) begin
      tx_bytes.push_back(8'($urandom));
      repeat (rounded) tx_bytes.push_back(8'($urandom));
    end
  endtask

  // Scoreboard: predict on every input transfer, compare on every result transfer.
  always @(posedge clk) begin : monitor
    slfe_result_t predicted;
    slfe_result_t seen;
    if (rst) begin
      parse_phase  = HUNT_SYNC0;
      fill_pos     = '0;
      payload_left = '0;
    end else begin
      if (rx_valid && rx_ready) begin
        predicted = parse_byte(rx_byte);
        // Hand-written rows override the prediction; the mirror still advances.
        if (n_accepted < directed_rows.size() && directed_rows[n_accepted].typed)
          predicted = directed_rows[n_accepted].want;
        pending_results.push_back(predicted);
        n_accepted++;
      end
      if (res_valid && res_ready) begin
        seen.byte_value        = byte_value;
        seen.kept              = kept;
        seen.byte_position     = byte_position;
        seen.candidate_dropped = candidate_dropped;
        seen.frame_done        = frame_done;
        seen.frame_length      = frame_length;
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected result %0d: byte %02h", n_results, byte_value);
        end else begin
          check_result(pending_results.pop_front(), seen);
        end
        n_results++;
      end
    end
  end

  // Receiver: random ready bursts, one long hold-off to back the block up, quiet tail.
  initial begin : receiver
    bit held_off;
    held_off  = 1'b0;
    res_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held_off && n_accepted >= directed_rows.size() + 200) begin
        held_off = 1'b1;
        res_ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        res_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // Build the stream, run the sender, then drain and report.
  initial begin : stimulus
    int n_random;
    int start;
    int pick;
    int len;
    bit max_done;

    rst      <= 1'b1;
    rx_valid <= 1'b0;
    rx_byte  <= '0;

    directed_rows = '{
      // noise while hunting is ignored
      stim_row(8'h00, 1, 0, 0, 0, 0, 0),
      stim_row(8'hFF, 1, 0, 0, 0, 0, 0),
      // repeated first sync byte: drop, then restart on the same byte
      stim_row(SYNC_0, 1, 1, 0, 0, 0, 0),
      stim_row(SYNC_0, 1, 1, 0, 1, 0, 0),
      stim_row(SYNC_1, 0, 0, 0, 0, 0, 0),
      // third sync byte wrong and not a first sync byte
      stim_row(8'h00, 1, 0, 0, 1, 0, 0),
      // zero length
      stim_row(SYNC_0, 0, 0, 0, 0, 0, 0),
      stim_row(SYNC_1, 0, 0, 0, 0, 0, 0),
      stim_row(SYNC_2, 0, 0, 0, 0, 0, 0),
      stim_row(8'h00, 0, 0, 0, 0, 0, 0),
      stim_row(8'h00, 1, 1, 4, 1, 0, 0),
      // length 0xFFFF rounds past 16 bits and is far too long
      stim_row(SYNC_0, 0, 0, 0, 0, 0, 0),
      stim_row(SYNC_1, 0, 0, 0, 0, 0, 0),
      stim_row(SYNC_2, 0, 0, 0, 0, 0, 0),
      stim_row(8'hFF, 0, 0, 0, 0, 0, 0),
      stim_row(8'hFF, 1, 1, 4, 1, 0, 0),
      // first sync byte arriving in place of the third
      stim_row(SYNC_0, 0, 0, 0, 0, 0, 0),
      stim_row(SYNC_1, 0, 0, 0, 0, 0, 0),
      stim_row(SYNC_0, 1, 1, 0, 1, 0, 0),
      // then the shortest frame: odd length 1 rounds to 2
      stim_row(SYNC_1, 0, 0, 0, 0, 0, 0),
      stim_row(SYNC_2, 0, 0, 0, 0, 0, 0),
      stim_row(8'h00, 0, 0, 0, 0, 0, 0),
      stim_row(8'h01, 0, 0, 0, 0, 0, 0),
      stim_row(8'h5A, 0, 0, 0, 0, 0, 0),
      stim_row(8'h00, 0, 0, 0, 0, 0, 0),
      stim_row(8'hFF, 1, 1, 7, 0, 1, 8)
    };
    foreach (directed_rows[i]) tx_bytes.push_back(directed_rows[i].rx);

    n_random = 0;
    max_done = 1'b0;
    while (n_random < RANDOM_ITEMS) begin
      start = tx_bytes.size();
      if (!max_done && n_random >= RANDOM_ITEMS / 2) begin
        // The first length past the limit: odd, so it rounds up over the frame size.
        push_frame(FRAME_BYTES - HEADER_BYTES + 1);
        max_done = 1'b1;
      end
      pick  = $urandom_range(0, 99);
      if (pick < 60) begin
        case ($urandom_range(0, 19))
          0, 1, 2:  len = $urandom_range(25, 160);
          3: begin
            case ($urandom_range(0, 5))
              0:       len = 0;
              1:       len = FRAME_BYTES - HEADER_BYTES + 1;
              2:       len = FRAME_BYTES - HEADER_BYTES + 2;
              3:       len = 16'hFFFE;
              4:       len = 16'hFFFF;
              default: len = $urandom_range(FRAME_BYTES, 65535);
            endcase
          end
          default:  len = $urandom_range(1, 24);
        endcase
        push_frame(len);
      end else if (pick < 72) begin
        // Broken sync word
        tx_bytes.push_back(SYNC_0);
        if ($urandom_range(0, 1)) tx_bytes.push_back(SYNC_1);
        tx_bytes.push_back(8'($urandom));
      end else if (pick < 84) begin
        // Header whose high length byte alone is already too long
        tx_bytes.push_back(SYNC_0);
        tx_bytes.push_back(SYNC_1);
        tx_bytes.push_back(SYNC_2);
        tx_bytes.push_back(8'($urandom_range(FRAME_BYTES >> 8, 255)));
        tx_bytes.push_back(8'($urandom));
      end else begin
        // Line noise: mostly ignored
        repeat ($urandom_range(1, 6)) tx_bytes.push_back(8'($urandom));
      end
      n_random += tx_bytes.size() - start;
    end

    // Odd length that rounds to the limit, header only: the limit itself is accepted.
    tx_bytes.push_back(SYNC_0);
    tx_bytes.push_back(SYNC_1);
    tx_bytes.push_back(SYNC_2);
    tx_bytes.push_back(8'((FRAME_BYTES - HEADER_BYTES - 1) >> 8));
    tx_bytes.push_back(8'(FRAME_BYTES - HEADER_BYTES - 1));
    tx_bytes.push_back(8'($urandom));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Offer each byte; hold valid and payload until the transfer.
    for (int i = 0; i < tx_bytes.size(); i++) begin
      quiet_tail = (i >= tx_bytes.size() - TAIL_ITEMS);
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        rx_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      rx_valid <= 1'b1;
      rx_byte  <= tx_bytes[i];
      @(posedge clk);
      while (!rx_ready) @(posedge clk);
    end
    rx_valid <= 1'b0;

    // Let the last prediction land, drain, then allow for stray results.
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/core/slfe_pkg.sv
rtl/core/slfe_in_stage.sv
rtl/core/slfe_parse.sv
rtl/core/slfe_out_stage.sv
rtl/core/sync_length_frame_extractor.sv
test/testbench.sv
